// ===== hw/rtl/ffla_pkg.sv =====
// ffla_pkg: shared types and constants for the flat face light accumulate block
// no dependencies; imported by ffla_blend, flat_face_light_accumulate and tb
package ffla_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int COORD_FRAC      = 8;
    localparam int NRM_W           = 16;
    localparam int FACT_W          = 21;

    localparam logic [FACT_W-1:0] F_ONE      = FACT_W'(65536);
    localparam logic [35:0]       FAR_LIMIT  = 36'h9_0000_0000;
    localparam logic [36:0]       DEN        = 37'(9 << (2 * COORD_FRAC));
    localparam logic [22:0]       RECIP_NINE = 23'd7456541;
    localparam int                RECIP_SH   = 26;

    localparam logic [23:0] LIGHT_COLOR_RST = 24'hCCCCCC;

    typedef enum logic [1:0] {
        MODE_AMBIENT = 2'd0,
        MODE_DIR     = 2'd1,
        MODE_POINT   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_COLOR   = 2'd1,
        REG_VECTOR  = 2'd2,
        REG_FALLOFF = 2'd3
    } reg_idx_t;

    typedef struct packed {
        mode_t           mode;
        logic [2:0][15:0] ab;
        logic [23:0]     shade;
        logic            last;
        logic            rate_zero;
    } carry_t;

endpackage

// ===== hw/rtl/flat_face_light_accumulate.sv =====
// flat_face_light_accumulate: an accepted input word passes stage registers one to eight to out_valid
// throughput one word per clock; the whole eight-stage pipe advances together
// and halts only while the output word is held by out_stall
// rst_n asynchronous active low: clears valid bits and the light registers
// (light_color resets to 0xCCCCCC, others to zero); payload registers are not reset
// depends on ffla_pkg and ffla_blend
module flat_face_light_accumulate
    import ffla_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [47:0] vertex_a,
    input  logic [47:0] vertex_b,
    input  logic [47:0] vertex_c,
    input  logic [47:0] face_normal,
    input  logic [23:0] face_color,
    input  logic [23:0] old_shade,
    input  logic        last_face,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] new_shade,
    output logic        last_out
);

    // widths that follow the coordinate lane width
    localparam int SW    = COORD_WIDTH + 3;          // three corners minus three positions
    localparam int SQW   = 2 * SW;                   // squared lane
    localparam int QW    = SQW + 2;                  // sum of three squares
    localparam int QCW   = (QW > 37) ? QW : 37;      // compare width against far limit
    localparam int DPW   = SW + NRM_W + 2;           // point dot sum
    localparam int EXT_W = 3 * COORD_WIDTH + 48;     // zero padded packing

    // ---------------- configuration registers ----------------
    logic [1:0]  light_mode_reg;
    logic [23:0] light_color_reg;
    logic [47:0] light_vector_reg;
    logic [15:0] falloff_rate_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_mode_reg   <= 2'd0;
            light_color_reg  <= LIGHT_COLOR_RST;
            light_vector_reg <= 48'd0;
            falloff_rate_reg <= 16'd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MODE:    light_mode_reg   <= pwdata[1:0];
                REG_COLOR:   light_color_reg  <= pwdata[23:0];
                REG_VECTOR:  light_vector_reg <= pwdata[47:0];
                REG_FALLOFF: falloff_rate_reg <= pwdata[15:0];
                default:     light_mode_reg   <= light_mode_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_MODE:    prdata = 64'(light_mode_reg);
            REG_COLOR:   prdata = 64'(light_color_reg);
            REG_VECTOR:  prdata = 64'(light_vector_reg);
            REG_FALLOFF: prdata = 64'(falloff_rate_reg);
            default:     prdata = 64'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // every stage moves when the output word is free or being taken
    logic       adv;
    logic [6:0] valid_reg;      // stages one through seven
    logic       out_valid_reg;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[5:0], in_valid};
            out_valid_reg <= valid_reg[6];
        end
    end

    // word fields that travel down the whole pipe
    carry_t carry_reg [1:7];

    // ---------------- stage 1: lane sums, directional products, color products ----------------
    logic [EXT_W-1:0] va_ext, vb_ext, vc_ext, lv_ext;
    logic signed [SW-1:0]  s_next [3];
    logic signed [31:0]    dprod_next [3];
    carry_t                c1_next;
    logic signed [SW-1:0]  s_reg [3];
    logic signed [31:0]    dprod_reg [3];
    logic [47:0]           nrm1_reg;

    assign va_ext = {{(3*COORD_WIDTH){1'b0}}, vertex_a};
    assign vb_ext = {{(3*COORD_WIDTH){1'b0}}, vertex_b};
    assign vc_ext = {{(3*COORD_WIDTH){1'b0}}, vertex_c};
    assign lv_ext = {{(3*COORD_WIDTH){1'b0}}, light_vector_reg};

    always_comb
    begin
        logic signed [COORD_WIDTH-1:0] la, lb, lc, lp;
        logic signed [NRM_W-1:0]       ln, nn;
        logic [7:0]                    c1;
        c1_next.mode      = mode_t'(light_mode_reg);
        c1_next.shade     = old_shade;
        c1_next.last      = last_face;
        c1_next.rate_zero = (falloff_rate_reg == 16'd0);
        for (int k = 0; k < 3; k++)
        begin
            la = signed'(va_ext[k*COORD_WIDTH +: COORD_WIDTH]);
            lb = signed'(vb_ext[k*COORD_WIDTH +: COORD_WIDTH]);
            lc = signed'(vc_ext[k*COORD_WIDTH +: COORD_WIDTH]);
            lp = signed'(lv_ext[k*COORD_WIDTH +: COORD_WIDTH]);
            s_next[k] = SW'(la) + SW'(lb) + SW'(lc) - (SW'(lp) <<< 1) - SW'(lp);
            ln = signed'(light_vector_reg[k*NRM_W +: NRM_W]);
            nn = signed'(face_normal[k*NRM_W +: NRM_W]);
            dprod_next[k] = 32'(ln) * 32'(nn);
            // directional light scales white, others the face color
            c1 = (light_mode_reg == MODE_DIR) ? 8'hFF : face_color[8*k +: 8];
            c1_next.ab[k] = 16'(c1) * 16'(light_color_reg[8*k +: 8]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg        <= s_next;
            dprod_reg    <= dprod_next;
            nrm1_reg     <= face_normal;
            carry_reg[1] <= c1_next;
        end
    end

    // ---------------- stage 2: squares, point products, directional factor ----------------
    logic [SQW-1:0]           sq_reg [3];
    logic signed [SW+15:0]    pprod_reg [3];
    logic [FACT_W-1:0]        fdir_reg;

    always_ff @(posedge clk)
    begin
        logic signed [33:0] dsum;
        logic        [33:0] dmag;
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k]    <= SQW'(s_reg[k] * s_reg[k]);
                pprod_reg[k] <= (SW+16)'(s_reg[k])
                              * (SW+16)'(signed'(nrm1_reg[k*NRM_W +: NRM_W]));
            end
            dsum = 34'(dprod_reg[0]) + 34'(dprod_reg[1]) + 34'(dprod_reg[2]);
            dmag = -dsum;
            // light must face the surface: only a negative dot lights it
            fdir_reg     <= dsum[33] ? FACT_W'(dmag[31:12]) : '0;
            carry_reg[2] <= carry_reg[1];
        end
    end

    // ---------------- stage 3: distance sum, facing test ----------------
    logic [35:0]       q36_reg;
    logic              far_reg;
    logic              facing_reg;
    logic [FACT_W-1:0] fdir3_reg;

    always_ff @(posedge clk)
    begin
        logic [QCW-1:0]        q;
        logic signed [DPW-1:0] pd;
        if (adv)
        begin
            q  = QCW'(sq_reg[0]) + QCW'(sq_reg[1]) + QCW'(sq_reg[2]);
            pd = DPW'(pprod_reg[0]) + DPW'(pprod_reg[1]) + DPW'(pprod_reg[2]);
            q36_reg      <= q[35:0];
            far_reg      <= (q >= QCW'(FAR_LIMIT));
            facing_reg   <= pd[DPW-1] || (pd == '0);
            fdir3_reg    <= fdir_reg;
            carry_reg[3] <= carry_reg[2];
        end
    end

    // ---------------- stage 4: distance times rolloff ----------------
    logic [51:0]       x_reg;
    logic              far4_reg, facing4_reg;
    logic [FACT_W-1:0] fdir4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg        <= 52'(q36_reg) * 52'(falloff_rate_reg);
            far4_reg     <= far_reg;
            facing4_reg  <= facing_reg;
            fdir4_reg    <= fdir3_reg;
            carry_reg[4] <= carry_reg[3];
        end
    end

    // ---------------- stage 5: ceiling divide, power of two part ----------------
    logic [19:0]       y_reg;
    logic              over_reg, facing5_reg;
    logic [FACT_W-1:0] fdir5_reg;

    always_ff @(posedge clk)
    begin
        logic [52:0] xr;
        logic [36:0] y;
        if (adv)
        begin
            xr = 53'(x_reg) + 53'(DEN - 37'd1);
            y  = xr[52:16];
            y_reg        <= y[19:0];
            // quotient of 65536 or more clamps the factor to zero
            over_reg     <= far4_reg || (y >= DEN);
            facing5_reg  <= facing4_reg;
            fdir5_reg    <= fdir4_reg;
            carry_reg[5] <= carry_reg[4];
        end
    end

    // ---------------- stage 6: divide by nine through reciprocal ----------------
    logic [42:0]       m_reg;
    logic              over6_reg, facing6_reg;
    logic [FACT_W-1:0] fdir6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg        <= 43'(y_reg) * 43'(RECIP_NINE);
            over6_reg    <= over_reg;
            facing6_reg  <= facing5_reg;
            fdir6_reg    <= fdir5_reg;
            carry_reg[6] <= carry_reg[5];
        end
    end

    // ---------------- stage 7: factor select per mode ----------------
    logic [FACT_W-1:0] fact_reg;

    always_ff @(posedge clk)
    begin
        logic [15:0]       t;
        logic [FACT_W-1:0] fpt;
        if (adv)
        begin
            t = m_reg[RECIP_SH+15:RECIP_SH];
            if (!facing6_reg)
                fpt = '0;
            else if (carry_reg[6].rate_zero)
                fpt = F_ONE;
            else if (over6_reg)
                fpt = '0;
            else
                fpt = F_ONE - FACT_W'(t);
            case (carry_reg[6].mode)
                MODE_AMBIENT: fact_reg <= F_ONE;
                MODE_DIR:     fact_reg <= fdir6_reg;
                MODE_POINT:   fact_reg <= fpt;
                default:      fact_reg <= '0;   // unused mode adds nothing
            endcase
            carry_reg[7] <= carry_reg[6];
        end
    end

    // ---------------- stage 8: channel blend into output word ----------------
    logic [23:0] shade_next;

    for (genvar k = 0; k < 3; k++)
    begin : g_ch
        ffla_blend u_blend
        (
            .ab     (carry_reg[7].ab[k]),
            .fact   (fact_reg),
            .old_ch (carry_reg[7].shade[8*k +: 8]),
            .new_ch (shade_next[8*k +: 8])
        );
    end

    logic [23:0] new_shade_reg;
    logic        last_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            new_shade_reg <= shade_next;
            last_out_reg  <= carry_reg[7].last;
        end
    end

    assign new_shade = new_shade_reg;
    assign last_out  = last_out_reg;

    // ---------------- assertions ----------------
    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output is free");

    a_pipe_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipe valid bits moved during a stall");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[6] && adv) |=> out_valid)
        else $error("word lost leaving the last stage");

endmodule

// ===== hw/rtl/ffla_blend.sv =====
// ffla_blend: one color channel, scaled product plus old shade, saturated
// depends on ffla_pkg
module ffla_blend
    import ffla_pkg::*;
(
    input  logic [15:0]       ab,
    input  logic [FACT_W-1:0] fact,
    input  logic [7:0]        old_ch,
    output logic [7:0]        new_ch
);

    logic [36:0] prod;
    logic [13:0] sum;

    always_comb
    begin
        prod = 37'(ab) * 37'(fact);
        sum  = 14'(prod[36:24]) + 14'(old_ch);
        if (sum > 14'd255)
        begin
            new_ch = 8'hFF;
        end
        else
        begin
            new_ch = sum[7:0];
        end
    end

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for flat_face_light_accumulate
// drives face words and register writes, checks new_shade and last_out against a predictor
// depends on ffla_pkg and the block rtl
module tb;
    import ffla_pkg::*;

    // stimulus row for the directed table
    typedef struct {
        logic [47:0] va;
        logic [47:0] vb;
        logic [47:0] vc;
        logic [47:0] nrm;
        logic [23:0] fcol;
        logic [23:0] shade;
        logic        last;
        logic        known;
        logic [23:0] want;
    } face_row_t;

    typedef struct {
        logic [23:0] shade;
        logic        last;
    } shade_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [47:0] vertex_a;
    logic [47:0] vertex_b;
    logic [47:0] vertex_c;
    logic [47:0] face_normal;
    logic [23:0] face_color;
    logic [23:0] old_shade;
    logic        last_face;
    logic        out_valid;
    logic        out_stall;
    logic [23:0] new_shade;
    logic        last_out;

    // predictor copy of the light registers
    mode_t       cur_mode;
    logic [23:0] cur_color;
    logic [47:0] cur_vector;
    logic [15:0] cur_falloff;

    shade_word_t pending_shades[$];
    int          n_errors;
    bit          quiet_tail;

    flat_face_light_accumulate u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
        .face_normal(face_normal), .face_color(face_color), .old_shade(old_shade),
        .last_face(last_face),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_shade(new_shade), .last_out(last_out)
    );

    always #1 clk = ~clk;

    function automatic longint lane_of(logic [47:0] packed_v, int idx);
        logic [15:0] raw;
        begin
            raw = packed_v[idx*16 +: 16];
            return longint'($signed(raw));
        end
    endfunction

    // per channel: shade + (c1*c2*f)>>24, saturated at 255
    function automatic logic [23:0] mix_channels(logic [23:0] c1, logic [23:0] c2,
                                                 longint unsigned f, logic [23:0] shade);
        logic [23:0]     res;
        longint unsigned sum;
        begin
            res = '0;
            for (int k = 0; k < 3; k++)
            begin
                sum = longint'(shade[8*k +: 8])
                    + ((longint'(c1[8*k +: 8]) * longint'(c2[8*k +: 8]) * f) >> 24);
                if (sum > 255)
                    sum = 255;
                res[8*k +: 8] = sum[7:0];
            end
            return res;
        end
    endfunction

    function automatic logic [23:0] shade_face(face_row_t r);
        longint          dot;
        longint          s;
        longint unsigned q;
        longint unsigned den;
        longint unsigned t;
        longint unsigned f;
        begin
            dot = 0;
            q   = 0;
            den = longint'(9) << (2 * COORD_FRAC);
            case (cur_mode)
                MODE_AMBIENT: return mix_channels(r.fcol, cur_color, 65536, r.shade);
                MODE_DIR:
                begin
                    for (int k = 0; k < 3; k++)
                        dot += lane_of(cur_vector, k) * lane_of(r.nrm, k);
                    if (dot < 0)
                        return mix_channels(24'hFFFFFF, cur_color,
                                            longint'(-dot) >> 12, r.shade);
                    return r.shade;
                end
                MODE_POINT:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        s = lane_of(r.va, k) + lane_of(r.vb, k) + lane_of(r.vc, k)
                          - 3 * lane_of(cur_vector, k);
                        dot += lane_of(r.nrm, k) * s;
                        q += longint'(s * s);
                    end
                    // facing away from the light: shade unchanged
                    if (dot > 0)
                        return r.shade;
                    if (cur_falloff == 0)
                        f = 65536;
                    else if (q >= (den << 16))
                        f = 0;
                    else
                    begin
                        t = (q * cur_falloff + den - 1) / den;
                        f = (t >= 65536) ? 0 : 65536 - t;
                    end
                    return mix_channels(r.fcol, cur_color, f, r.shade);
                end
                default: return r.shade;
            endcase
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        begin
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
            n_errors++;
        end
    endtask

    // output side: compare every accepted word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_shades.size() == 0)
                report_mismatch("unexpected word", {8'h0, new_shade}, 32'h0);
            else
            begin
                shade_word_t w;
                w = pending_shades.pop_front();
                if (new_shade !== w.shade)
                    report_mismatch("new_shade", {8'h0, new_shade}, {8'h0, w.shade});
                if (last_out !== w.last)
                    report_mismatch("last_out", {31'h0, last_out}, {31'h0, w.last});
            end
        end
    end

    // receiver stall in bursts of random length
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // register write: setup then access cycle
    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 5'(idx) << 3;
            pwdata  <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            case (idx)
                REG_MODE:    cur_mode    = mode_t'(value[1:0]);
                REG_COLOR:   cur_color   = value[23:0];
                REG_VECTOR:  cur_vector  = value[47:0];
                REG_FALLOFF: cur_falloff = value[15:0];
            endcase
        end
    endtask

    // wait for all expected words to be checked
    task automatic drain;
        begin
            while (pending_shades.size() != 0) @(posedge clk);
            repeat (12) @(posedge clk);
        end
    endtask

    task automatic set_light(mode_t m, logic [23:0] col, logic [47:0] vec, logic [15:0] fr);
        begin
            drain();
            write_reg(REG_MODE, 64'(m));
            write_reg(REG_COLOR, 64'(col));
            write_reg(REG_VECTOR, 64'(vec));
            write_reg(REG_FALLOFF, 64'(fr));
        end
    endtask

    // send one face word, with optional idle burst before it
    task automatic send_face(face_row_t r);
        shade_word_t w;
        int          gap;
        begin
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 5);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid    <= 1'b1;
            vertex_a    <= r.va;
            vertex_b    <= r.vb;
            vertex_c    <= r.vc;
            face_normal <= r.nrm;
            face_color  <= r.fcol;
            old_shade   <= r.shade;
            last_face   <= r.last;
            w.shade = shade_face(r);
            w.last  = r.last;
            if (r.known && w.shade !== r.want)
                report_mismatch("table row", {8'h0, w.shade}, {8'h0, r.want});
            @(posedge clk);
            while (in_stall) @(posedge clk);
            // accepted at this edge
            pending_shades.push_back(w);
        end
    endtask

    task automatic idle_input;
        begin
            in_valid <= 1'b0;
        end
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // small coordinates keep point lights in range more often
    function automatic logic [47:0] near_coord();
        logic [47:0] v;
        begin
            for (int k = 0; k < 3; k++)
                v[16*k +: 16] = 16'($signed($urandom_range(0, 2048)) - 1024);
            return v;
        end
    endfunction

    function automatic face_row_t rand_face(bit near);
        face_row_t r;
        begin
            r.va    = near ? near_coord() : rand48();
            r.vb    = near ? near_coord() : rand48();
            r.vc    = near ? near_coord() : rand48();
            r.nrm   = rand48();
            r.fcol  = 24'($urandom);
            r.shade = ($urandom_range(0, 3) == 0) ? 24'h0 : 24'($urandom);
            r.last  = 1'($urandom);
            r.known = 1'b0;
            r.want  = '0;
            return r;
        end
    endfunction

    face_row_t dir_rows[$];

    initial
    begin
        face_row_t r;
        mode_t     m;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0;
        vertex_a = '0; vertex_b = '0; vertex_c = '0; face_normal = '0;
        face_color = '0; old_shade = '0; last_face = 1'b0;
        n_errors = 0;
        quiet_tail = 1'b0;
        cur_mode = MODE_AMBIENT;
        cur_color = LIGHT_COLOR_RST;
        cur_vector = '0;
        cur_falloff = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset light: black and white extremes
        dir_rows.push_back('{48'h0, 48'h0, 48'h0, 48'h0, 24'h000000, 24'h000000, 1'b0,
                             1'b1, 24'h000000});
        dir_rows.push_back('{48'h0, 48'h0, 48'h0, 48'h0, 24'hFFFFFF, 24'h000000, 1'b1,
                             1'b1, 24'hCBCBCB});
        dir_rows.push_back('{48'hFFFFFFFFFFFF, 48'h800080008000, 48'h7FFF7FFF7FFF,
                             48'hFFFFFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0,
                             1'b1, 24'hFFFFFF});
        foreach (dir_rows[i]) send_face(dir_rows[i]);
        idle_input();

        // full light, every mode, including the unused one and a zero-falloff point
        set_light(MODE_AMBIENT, 24'hFFFFFF, 48'h0, 16'h0);
        send_face('{48'h0, 48'h0, 48'h0, 48'h0, 24'hFFFFFF, 24'h000000, 1'b1,
                    1'b1, 24'hFEFEFE});
        idle_input();
        set_light(MODE_NONE, 24'hFFFFFF, rand48(), 16'hFFFF);
        send_face('{48'h0, 48'h0, 48'h0, 48'h0, 24'hFFFFFF, 24'h123456, 1'b0,
                    1'b1, 24'h123456});
        idle_input();
        // directional, light along -z against +z normal: factor 1.0
        set_light(MODE_DIR, 24'hFFFFFF, 48'hC000_0000_0000, 16'h0);
        send_face('{48'h0, 48'h0, 48'h0, 48'h4000_0000_0000, 24'h0, 24'h000000, 1'b0,
                    1'b1, 24'hFEFEFE});
        // normal facing the same way: no light
        send_face('{48'h0, 48'h0, 48'h0, 48'hC000_0000_0000, 24'h0, 24'h010203, 1'b1,
                    1'b1, 24'h010203});
        // non-unit: extreme lanes, saturation bounds it
        send_face('{48'h0, 48'h0, 48'h0, 48'h800080008000, 24'h0, 24'h808080, 1'b0,
                    1'b0, 24'h0});
        idle_input();
        set_light(MODE_DIR, 24'hFFFFFF, 48'h7FFF7FFF7FFF, 16'h0);
        send_face('{48'h0, 48'h0, 48'h0, 48'h800080008000, 24'h0, 24'h808080, 1'b0,
                    1'b0, 24'h0});
        idle_input();
        // point: facing away leaves shade, zero falloff gives full light
        set_light(MODE_POINT, 24'h808080, 48'h0, 16'h0);
        send_face('{48'h0100, 48'h0100, 48'h0100, 48'h4000, 24'hFFFFFF, 24'h111111, 1'b0,
                    1'b1, 24'h111111});
        send_face('{48'h0100, 48'h0100, 48'h0100, 48'hC000, 24'hFFFFFF, 24'h000000, 1'b1,
                    1'b1, 24'h7F7F7F});
        idle_input();
        set_light(MODE_POINT, 24'hFFFFFF, 48'h0, 16'hFFFF);
        send_face('{48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF, 48'h0,
                    24'hFFFFFF, 24'h222222, 1'b0, 1'b1, 24'h222222});
        send_face('{48'h0080, 48'h0, 48'h0, 48'h0, 24'hFFFFFF, 24'h0, 1'b0, 1'b0, 24'h0});
        send_face('{48'h800080008000, 48'h800080008000, 48'h800080008000, 48'h0,
                    24'h0F0F0F, 24'h0, 1'b1, 1'b0, 24'h0});
        idle_input();

        // random phases across settings
        for (int ph = 0; ph < 22; ph++)
        begin
            m = mode_t'($urandom_range(0, 3));
            if (ph < 8)
                m = mode_t'(ph % 4);
            set_light(m, ($urandom_range(0, 4) == 0) ? 24'hFFFFFF : 24'($urandom),
                      (m == MODE_POINT) ? near_coord() : rand48(),
                      ($urandom_range(0, 4) == 0) ? 16'h0 :
                      ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 255)));
            if (ph == 21)
                quiet_tail = 1'b1;
            for (int i = 0; i < 50; i++)
            begin
                r = rand_face(cur_mode == MODE_POINT && $urandom_range(0, 3) != 0);
                send_face(r);
            end
            idle_input();
        end

        drain();
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end
endmodule
